// File: sv/integer_text_formatter_assert.svh
// Assertion macros used by the integer text formatter top level
`ifndef INTEGER_TEXT_FORMATTER_ASSERT_SVH
`define INTEGER_TEXT_FORMATTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define ITF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("integer_text_formatter assertion failed");
`define ITF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("integer_text_formatter assertion failed");
`else
`define ITF_ASSERT(lbl, prop)
`define ITF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: sv/itf_pkg.sv
// Shared types, character codes and base codes of the integer text formatter
package itf_pkg;

  localparam logic [1:0] BASE_OCT    = 2'd0;
  localparam logic [1:0] BASE_DEC    = 2'd1;
  localparam logic [1:0] BASE_HEX_LC = 2'd2;
  localparam logic [1:0] BASE_HEX_UC = 2'd3;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic       negative;
    logic       force_plus;
    logic       zero_pad;
    logic       left_adjust;
    logic       upper;
    logic [6:0] field_width;
  } fmt_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] alpha;
    alpha = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = alpha + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

// File: sv/itf_digit_conv.sv
// Bit-serial binary to octal, decimal or hex digit converter
module itf_digit_conv #(
  parameter int VALUE_BITS = 64,
  parameter int DIGITS     = 22,
  parameter int CW         = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [VALUE_BITS-1:0]      value,
  input  logic [1:0]                 base,
  output itf_pkg::conv_stat_t        stat,
  output logic [DIGITS-1:0][3:0]     digits,
  output logic [CW-1:0]              ndig
);

  localparam int BCW = $clog2(VALUE_BITS);
  localparam int IW  = $clog2(DIGITS);

  logic [VALUE_BITS-1:0]  shreg_r, shreg_nxt;
  logic [BCW-1:0]         bitcnt_r, bitcnt_nxt;
  logic [DIGITS-1:0][3:0] dig_r, dig_nxt;
  logic [CW-1:0]          ndig_r, ndig_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [1:0]             base_r;

  logic [DIGITS-1:0][3:0] adj;
  logic [DIGITS-1:0][3:0] shifted;
  logic [DIGITS-1:0]      carry;
  logic [CW-1:0]          top_idx;
  logic                   is_oct;
  logic                   is_dec;

  always_comb begin
    is_oct = (base_r == itf_pkg::BASE_OCT);
    is_dec = (base_r == itf_pkg::BASE_DEC);
    for (int i = 0; i < DIGITS; i++) begin
      adj[i]   = (is_dec && (dig_r[i] >= 4'd5)) ? dig_r[i] + 4'd3 : dig_r[i];
      carry[i] = is_oct ? adj[i][2] : adj[i][3];
    end
    shifted[0] = is_oct ? {1'b0, adj[0][1:0], shreg_r[VALUE_BITS-1]}
                        : {adj[0][2:0], shreg_r[VALUE_BITS-1]};
    for (int i = 1; i < DIGITS; i++) begin
      shifted[i] = is_oct ? {1'b0, adj[i][1:0], carry[i-1]} : {adj[i][2:0], carry[i-1]};
    end
    top_idx = ndig_r - CW'(1);
  end

  always_comb begin
    shreg_nxt  = shreg_r;
    bitcnt_nxt = bitcnt_r;
    dig_nxt    = dig_r;
    ndig_nxt   = ndig_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (start) begin
      shreg_nxt  = value;
      bitcnt_nxt = BCW'(VALUE_BITS - 1);
      dig_nxt    = '0;
      ndig_nxt   = CW'(1);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      shreg_nxt = shreg_r << 1;
      dig_nxt   = shifted;
      if (carry[top_idx[IW-1:0]] && (ndig_r != CW'(DIGITS))) begin
        ndig_nxt = ndig_r + CW'(1);
      end
      if (bitcnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bitcnt_nxt = bitcnt_r - BCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r  <= shreg_nxt;
    bitcnt_r <= bitcnt_nxt;
    dig_r    <= dig_nxt;
    ndig_r   <= ndig_nxt;
    if (start) begin
      base_r <= base;
    end
  end

  assign stat.busy = busy_r | done_r;
  assign stat.done = done_r;
  assign digits    = dig_r;
  assign ndig      = ndig_r;

endmodule

// File: sv/itf_emit.sv
// Character sequencer and output register of the integer text formatter
module itf_emit #(
  parameter int MAX_FIELD_WIDTH = 64,
  parameter int DIGITS          = 22,
  parameter int CW              = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  itf_pkg::fmt_t          fmt,
  input  logic [DIGITS-1:0][3:0] digits,
  input  logic [CW-1:0]          ndig,
  output logic                   busy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_text_char,
  output logic                   out_last_char
);

  localparam int IW = $clog2(DIGITS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LSP  = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_ZERO = 3'd3;
  localparam logic [2:0] ST_DIG  = 3'd4;
  localparam logic [2:0] ST_RSP  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [IW-1:0] dptr_r, dptr_nxt;
  logic          zer_r, zer_nxt;
  logic          rsp_r, rsp_nxt;
  logic          sgn_r, sgn_nxt;
  logic          neg_r, neg_nxt;
  logic          upper_r, upper_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          last_r, last_nxt;

  logic [6:0]    wsat;
  logic [6:0]    numlen;
  logic [6:0]    pad;
  logic [CW-1:0] ndig_m1;
  logic          dosign;
  logic          has_pad;
  logic          advance;

  always_comb begin
    dosign  = fmt.negative | fmt.force_plus;
    wsat    = (fmt.field_width > 7'(MAX_FIELD_WIDTH)) ? 7'(MAX_FIELD_WIDTH)
                                                      : fmt.field_width;
    numlen  = 7'(ndig) + {6'd0, dosign};
    pad     = (wsat > numlen) ? wsat - numlen : 7'd0;
    has_pad = (pad != 7'd0);
    ndig_m1 = ndig - CW'(1);
    advance = (state_r != ST_IDLE) && (!ov_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dptr_nxt  = dptr_r;
    zer_nxt   = zer_r;
    rsp_nxt   = rsp_r;
    sgn_nxt   = sgn_r;
    neg_nxt   = neg_r;
    upper_nxt = upper_r;
    ov_nxt    = ov_r;
    ch_nxt    = ch_r;
    last_nxt  = last_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (advance) begin
      ov_nxt   = 1'b1;
      last_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          zer_nxt   = has_pad & fmt.zero_pad;
          rsp_nxt   = has_pad & ~fmt.zero_pad & fmt.left_adjust;
          sgn_nxt   = dosign;
          neg_nxt   = fmt.negative;
          upper_nxt = fmt.upper;
          cnt_nxt   = pad;
          dptr_nxt  = ndig_m1[IW-1:0];
          if (has_pad && !fmt.zero_pad && !fmt.left_adjust) begin
            state_nxt = ST_LSP;
          end else if (dosign) begin
            state_nxt = ST_SIGN;
          end else if (has_pad && fmt.zero_pad) begin
            state_nxt = ST_ZERO;
          end else begin
            state_nxt = ST_DIG;
          end
        end
      end
      ST_LSP: begin
        if (advance) begin
          ch_nxt  = itf_pkg::CH_SPACE;
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            state_nxt = sgn_r ? ST_SIGN : ST_DIG;
          end
        end
      end
      ST_SIGN: begin
        if (advance) begin
          ch_nxt    = neg_r ? itf_pkg::CH_MINUS : itf_pkg::CH_PLUS;
          state_nxt = zer_r ? ST_ZERO : ST_DIG;
        end
      end
      ST_ZERO: begin
        if (advance) begin
          ch_nxt  = itf_pkg::CH_ZERO;
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            state_nxt = ST_DIG;
          end
        end
      end
      ST_DIG: begin
        if (advance) begin
          ch_nxt = itf_pkg::digit_char(digits[dptr_r], upper_r);
          if (dptr_r == '0) begin
            if (rsp_r) begin
              state_nxt = ST_RSP;
            end else begin
              state_nxt = ST_IDLE;
              last_nxt  = 1'b1;
            end
          end else begin
            dptr_nxt = dptr_r - IW'(1);
          end
        end
      end
      ST_RSP: begin
        if (advance) begin
          ch_nxt  = itf_pkg::CH_SPACE;
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            state_nxt = ST_IDLE;
            last_nxt  = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    dptr_r  <= dptr_nxt;
    zer_r   <= zer_nxt;
    rsp_r   <= rsp_nxt;
    sgn_r   <= sgn_nxt;
    neg_r   <= neg_nxt;
    upper_r <= upper_nxt;
    ch_r    <= ch_nxt;
    last_r  <= last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = ov_r;
  assign out_text_char = ch_r;
  assign out_last_char = last_r;

endmodule

// File: sv/integer_text_formatter.sv
// Top level of the integer text formatter
// Formats one integer per request as printf does (octal, decimal or hex, field width,
// zero-pad, left-adjust and plus flags) and sends the text one ASCII character per
// output request, the last one flagged by out_last_char. A request is taken, then the
// value is shifted bit by bit into a digit register, the character sequencer sets up
// the padding, and then one character leaves per cycle while out_stall is low. The next
// request is taken as soon as the last character sits in the output register.
`include "integer_text_formatter_assert.svh"
module integer_text_formatter #(
  parameter int MAX_FIELD_WIDTH = 64,
  parameter int VALUE_BITS      = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_magnitude,
  input  logic        in_negative,
  input  logic [1:0]  in_base_select,
  input  logic [6:0]  in_field_width,
  input  logic        in_zero_pad,
  input  logic        in_left_adjust,
  input  logic        in_force_plus,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_text_char,
  output logic        out_last_char
);

  localparam int DIGITS = (VALUE_BITS + 2) / 3;
  localparam int CW     = $clog2(DIGITS + 1);

  itf_pkg::conv_stat_t    conv_st;
  itf_pkg::fmt_t          fmt_r, fmt_nxt;
  logic [DIGITS-1:0][3:0] digits;
  logic [CW-1:0]          ndig;
  logic                   emit_busy;
  logic                   in_acc;

  assign in_stall = conv_st.busy | emit_busy;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    fmt_nxt.negative    = in_negative;
    fmt_nxt.force_plus  = in_force_plus;
    fmt_nxt.zero_pad    = in_zero_pad;
    fmt_nxt.left_adjust = in_left_adjust;
    fmt_nxt.upper       = (in_base_select == itf_pkg::BASE_HEX_UC);
    fmt_nxt.field_width = in_field_width;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fmt_r <= fmt_nxt;
    end
  end

  itf_digit_conv #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS),
    .CW         (CW)
  ) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .value  (in_magnitude[VALUE_BITS-1:0]),
    .base   (in_base_select),
    .stat   (conv_st),
    .digits (digits),
    .ndig   (ndig)
  );

  itf_emit #(
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
    .DIGITS          (DIGITS),
    .CW              (CW)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (conv_st.done),
    .fmt           (fmt_r),
    .digits        (digits),
    .ndig          (ndig),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  `ITF_ASSERT(a_accept_starts_conv, in_acc |=> conv_st.busy)
  `ITF_ASSERT(a_done_needs_idle_emit, conv_st.done |-> !emit_busy)
  `ITF_ASSERT(a_digits_held_while_emit, emit_busy |-> !conv_st.busy)
  `ITF_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid)

endmodule
